FILE: hdl/tdrr_pkg.sv
package tdrr_pkg;

    localparam int DEPTH     = 16;
    localparam int WORD_BITS = 32;
    localparam int IDX_W     = $clog2(DEPTH);
    localparam int CNT_W     = $clog2(DEPTH + 1);
    localparam int CMD_W     = 3;
    localparam int POS_W     = 4;
    localparam int STATUS_W  = 2;

    typedef enum logic [CMD_W-1:0] {
        CMD_PUSH_BACK  = 3'd0,
        CMD_PUSH_FRONT = 3'd1,
        CMD_POP_FRONT  = 3'd2,
        CMD_REMOVE     = 3'd3,
        CMD_REVERSE    = 3'd4,
        CMD_SEARCH     = 3'd5,
        CMD_READ       = 3'd6
    } t_cmd;

    typedef enum logic [STATUS_W-1:0] {
        STAT_OK    = 2'd0,
        STAT_EMPTY = 2'd1,
        STAT_FULL  = 2'd2,
        STAT_RANGE = 2'd3
    } t_status;

    typedef enum logic {
        S_IDLE,
        S_SCAN
    } t_state;

    typedef enum logic [1:0] {
        CELL_HOLD,
        CELL_LOAD,
        CELL_TAKE_LEFT,
        CELL_TAKE_RIGHT
    } t_cell_op;

    typedef struct packed {
        logic signed [WORD_BITS-1:0] a;
        logic signed [WORD_BITS-1:0] b;
        logic signed [WORD_BITS-1:0] c;
    } t_tuple;

    typedef struct packed {
        logic [CMD_W-1:0]            cmd;
        logic signed [WORD_BITS-1:0] word_a;
        logic signed [WORD_BITS-1:0] word_b;
        logic signed [WORD_BITS-1:0] word_c;
        logic [POS_W-1:0]            position;
    } t_in_item;

    typedef struct packed {
        logic [STATUS_W-1:0]         status;
        logic                        found;
        logic [CNT_W-1:0]            removed_count;
        logic [CNT_W-1:0]            entry_count;
        logic signed [WORD_BITS-1:0] out_a;
        logic signed [WORD_BITS-1:0] out_b;
        logic signed [WORD_BITS-1:0] out_c;
    } t_out_item;

endpackage

FILE: hdl/tdrr_cell.sv
module tdrr_cell (
    input  logic              i_clk,
    input  tdrr_pkg::t_cell_op i_op,
    input  tdrr_pkg::t_tuple  i_new,
    input  tdrr_pkg::t_tuple  i_left,
    input  tdrr_pkg::t_tuple  i_right,
    input  tdrr_pkg::t_tuple  i_key,
    output tdrr_pkg::t_tuple  o_data,
    output logic              o_match
);
    import tdrr_pkg::*;

    t_tuple r_data;
    t_tuple n_data;

    always_comb begin
        case (i_op)
            CELL_HOLD:       n_data = r_data;
            CELL_LOAD:       n_data = i_new;
            CELL_TAKE_LEFT:  n_data = i_left;
            CELL_TAKE_RIGHT: n_data = i_right;
            default:         n_data = r_data;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_data <= n_data;
    end

    assign o_data  = r_data;
    assign o_match = (r_data == i_key);

endmodule

FILE: hdl/tuple_deque_remove_reverse.sv
// Bounded deque of up to 16 three-word signed tuples, kept in a row of cells
// (cell 0 at one end) plus a direction flag, so reverse is a flag toggle and
// push at the cell 0 end shifts every cell one place along the row. Push, pop,
// reverse, read and the unused code give their result beat in the cycle after
// the accepted beat. Remove and search walk the row one cell a cycle through a
// single selector over the cells' match flags; remove walks every entry held,
// while search stops at the first hit. A removed entry is closed up by
// shifting the cells above it down in the same cycle. One command is in the
// block at a time; a new beat is taken once the walk is over and the result
// register is empty or being emptied.
module tuple_deque_remove_reverse (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  tdrr_pkg::t_in_item i_in_data,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output tdrr_pkg::t_out_item o_out_data
);
    import tdrr_pkg::*;

    t_state           r_state, n_state;
    logic [CNT_W-1:0] r_n, n_n;
    logic             r_rev, n_rev;
    logic [CNT_W-1:0] r_idx, n_idx;
    logic [CNT_W-1:0] r_rem, n_rem;
    logic             r_search, n_search;
    t_tuple           r_key, n_key;
    logic             r_out_valid, n_out_valid;
    t_out_item        r_out, n_out;

    t_cell_op         w_op    [DEPTH];
    t_tuple           w_data  [DEPTH];
    t_tuple           w_left  [DEPTH];
    t_tuple           w_right [DEPTH];
    logic [DEPTH-1:0] w_match;
    t_tuple           w_new;
    logic             w_in_fire;
    logic [IDX_W-1:0] w_rd_idx;

    assign w_new.a = i_in_data.word_a;
    assign w_new.b = i_in_data.word_b;
    assign w_new.c = i_in_data.word_c;

    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        if (g == 0) begin : g_head
            assign w_left[g] = w_new;
        end else begin : g_body
            assign w_left[g] = w_data[g-1];
        end
        if (g == DEPTH - 1) begin : g_tail
            assign w_right[g] = w_data[g];
        end else begin : g_inner
            assign w_right[g] = w_data[g+1];
        end

        tdrr_cell u_cell (
            .i_clk   (i_clk),
            .i_op    (w_op[g]),
            .i_new   (w_new),
            .i_left  (w_left[g]),
            .i_right (w_right[g]),
            .i_key   (r_key),
            .o_data  (w_data[g]),
            .o_match (w_match[g])
        );
    end

    assign o_in_ready  = (r_state == S_IDLE) && (!r_out_valid || i_out_ready);
    assign w_in_fire   = i_in_valid && o_in_ready;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    // position from the front maps onto the far end of the row when reversed
    assign w_rd_idx = r_rev
        ? IDX_W'(r_n - CNT_W'(1) - CNT_W'(i_in_data.position))
        : IDX_W'(i_in_data.position);

    always_comb begin
        t_out_item        res;
        logic             emit;
        logic             at_tail;
        logic             hit;
        logic             last;

        n_state     = r_state;
        n_n         = r_n;
        n_rev       = r_rev;
        n_idx       = r_idx;
        n_rem       = r_rem;
        n_search    = r_search;
        n_key       = r_key;
        n_out_valid = r_out_valid && !i_out_ready;
        n_out       = r_out;
        emit        = 1'b0;
        at_tail     = 1'b0;
        hit         = w_match[r_idx[IDX_W-1:0]];
        last        = (CNT_W'(r_idx + CNT_W'(1)) == r_n);
        res         = '0;
        res.entry_count = r_n;
        for (int j = 0; j < DEPTH; j++) begin
            w_op[j] = CELL_HOLD;
        end

        case (r_state)
            S_IDLE: begin
                if (w_in_fire) begin
                    emit = 1'b1;
                    case (t_cmd'(i_in_data.cmd))
                        CMD_PUSH_BACK, CMD_PUSH_FRONT: begin
                            if (r_n == CNT_W'(DEPTH)) begin
                                res.status = STAT_FULL;
                            end else begin
                                at_tail = (t_cmd'(i_in_data.cmd) == CMD_PUSH_BACK) ^ r_rev;
                                for (int j = 0; j < DEPTH; j++) begin
                                    if (at_tail) begin
                                        if (IDX_W'(j) == r_n[IDX_W-1:0]) begin
                                            w_op[j] = CELL_LOAD;
                                        end
                                    end else begin
                                        w_op[j] = (j == 0) ? CELL_LOAD : CELL_TAKE_LEFT;
                                    end
                                end
                                n_n = r_n + CNT_W'(1);
                                res.entry_count = n_n;
                            end
                        end
                        CMD_POP_FRONT: begin
                            if (r_n == '0) begin
                                res.status = STAT_EMPTY;
                            end else begin
                                if (!r_rev) begin
                                    for (int j = 0; j < DEPTH; j++) begin
                                        w_op[j] = CELL_TAKE_RIGHT;
                                    end
                                end
                                n_n = r_n - CNT_W'(1);
                                res.removed_count = CNT_W'(1);
                                res.entry_count   = n_n;
                            end
                        end
                        CMD_REMOVE, CMD_SEARCH: begin
                            if (r_n == '0) begin
                                if (t_cmd'(i_in_data.cmd) == CMD_REMOVE) begin
                                    res.status = STAT_EMPTY;
                                end
                            end else begin
                                emit     = 1'b0;
                                n_state  = S_SCAN;
                                n_idx    = '0;
                                n_rem    = '0;
                                n_search = (t_cmd'(i_in_data.cmd) == CMD_SEARCH);
                                n_key    = w_new;
                            end
                        end
                        CMD_REVERSE: begin
                            if (r_n == '0) begin
                                res.status = STAT_EMPTY;
                            end else begin
                                n_rev = !r_rev;
                            end
                        end
                        CMD_READ: begin
                            if (CNT_W'(i_in_data.position) >= r_n) begin
                                res.status = STAT_RANGE;
                            end else begin
                                res.out_a = w_data[w_rd_idx].a;
                                res.out_b = w_data[w_rd_idx].b;
                                res.out_c = w_data[w_rd_idx].c;
                            end
                        end
                        default: begin
                            res.status = STAT_OK;
                        end
                    endcase
                end
            end
            S_SCAN: begin
                if (r_search) begin
                    if (hit || last) begin
                        emit      = 1'b1;
                        res.found = hit;
                        n_state   = S_IDLE;
                    end else begin
                        n_idx = r_idx + CNT_W'(1);
                    end
                end else begin
                    if (hit) begin
                        // close the gap: every cell from the hit upwards takes its neighbour
                        for (int j = 0; j < DEPTH; j++) begin
                            if (CNT_W'(j) >= r_idx) begin
                                w_op[j] = CELL_TAKE_RIGHT;
                            end
                        end
                        n_n   = r_n - CNT_W'(1);
                        n_rem = r_rem + CNT_W'(1);
                    end else if (!last) begin
                        n_idx = r_idx + CNT_W'(1);
                    end
                    if (last) begin
                        emit              = 1'b1;
                        res.removed_count = n_rem;
                        res.entry_count   = n_n;
                        n_state           = S_IDLE;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        if (emit) begin
            n_out_valid = 1'b1;
            n_out       = res;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_n         <= '0;
            r_rev       <= 1'b0;
            r_idx       <= '0;
            r_rem       <= '0;
            r_search    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_n         <= n_n;
            r_rev       <= n_rev;
            r_idx       <= n_idx;
            r_rem       <= n_rem;
            r_search    <= n_search;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_key <= n_key;
        r_out <= n_out;
    end

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_n <= CNT_W'(DEPTH))
        else $error("entry count above depth");

    a_scan_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN) |-> (r_idx < r_n))
        else $error("walk index past the stored entries");

    a_scan_no_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN) |-> !r_out_valid)
        else $error("result beat pending during a walk");

    a_count_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) |-> ((r_n == $past(r_n)) || (r_n == $past(r_n) + CNT_W'(1))
                            || (r_n + CNT_W'(1) == $past(r_n))))
        else $error("entry count moved by more than one");

    a_walk_ends_with_beat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == S_SCAN) && (n_state == S_IDLE)) |=> r_out_valid)
        else $error("walk finished without a result beat");
`endif

endmodule

FILE: sim/tdrr_result_monitor.sv
module tdrr_result_monitor (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    input  logic                i_in_ready,
    input  tdrr_pkg::t_in_item  i_in_data,
    input  logic                i_out_valid,
    input  logic                i_out_ready,
    input  tdrr_pkg::t_out_item i_out_data,
    output int                  o_fail_count,
    output int                  o_pending
);
    import tdrr_pkg::*;

    // held tuples in logical order, front first
    t_tuple    entries[$];
    t_out_item awaited[$];
    t_out_item want;
    int        fails = 0;

    function automatic t_out_item apply_command(t_in_item it);
        t_out_item res;
        t_tuple    key;
        t_tuple    kept[$];
        int        dropped;
        res     = '0;
        dropped = 0;
        key     = '{a: it.word_a, b: it.word_b, c: it.word_c};
        case (it.cmd)
            CMD_PUSH_BACK, CMD_PUSH_FRONT: begin
                if (entries.size() >= DEPTH) begin
                    res.status = STAT_FULL;
                end else if (it.cmd == CMD_PUSH_BACK) begin
                    entries.push_back(key);
                end else begin
                    entries.push_front(key);
                end
            end
            CMD_POP_FRONT: begin
                if (entries.size() == 0) begin
                    res.status = STAT_EMPTY;
                end else begin
                    void'(entries.pop_front());
                    res.removed_count = CNT_W'(1);
                end
            end
            CMD_REMOVE: begin
                if (entries.size() == 0) begin
                    res.status = STAT_EMPTY;
                end else begin
                    // survivors keep their order
                    foreach (entries[i]) begin
                        if (entries[i] == key) dropped++;
                        else kept.push_back(entries[i]);
                    end
                    entries = kept;
                    res.removed_count = CNT_W'(dropped);
                end
            end
            CMD_REVERSE: begin
                if (entries.size() == 0) begin
                    res.status = STAT_EMPTY;
                end else begin
                    for (int i = entries.size() - 1; i >= 0; i--) kept.push_back(entries[i]);
                    entries = kept;
                end
            end
            CMD_SEARCH: begin
                foreach (entries[i]) begin
                    if (entries[i] == key) res.found = 1'b1;
                end
            end
            CMD_READ: begin
                if (int'(it.position) >= entries.size()) begin
                    res.status = STAT_RANGE;
                end else begin
                    res.out_a = entries[it.position].a;
                    res.out_b = entries[it.position].b;
                    res.out_c = entries[it.position].c;
                end
            end
            default: begin
                // spare code: no effect
            end
        endcase
        res.entry_count = CNT_W'(entries.size());
        return res;
    endfunction

    function automatic void check_field(string name, logic [WORD_BITS-1:0] exp_v,
                                        logic [WORD_BITS-1:0] got_v);
        if (got_v !== exp_v) begin
            fails++;
            $display("%0t: %s expected %0h actual %0h", $time, name, exp_v, got_v);
        end
    endfunction

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            // result beat first: it can never belong to a command taken on this edge
            if (i_out_valid && i_out_ready) begin
                if (awaited.size() == 0) begin
                    fails++;
                    $display("%0t: unexpected result beat, actual %0h", $time, i_out_data);
                end else begin
                    want = awaited.pop_front();
                    check_field("status", WORD_BITS'(want.status),
                                WORD_BITS'(i_out_data.status));
                    check_field("found", WORD_BITS'(want.found),
                                WORD_BITS'(i_out_data.found));
                    check_field("removed_count", WORD_BITS'(want.removed_count),
                                WORD_BITS'(i_out_data.removed_count));
                    check_field("entry_count", WORD_BITS'(want.entry_count),
                                WORD_BITS'(i_out_data.entry_count));
                    check_field("out_a", want.out_a, i_out_data.out_a);
                    check_field("out_b", want.out_b, i_out_data.out_b);
                    check_field("out_c", want.out_c, i_out_data.out_c);
                end
            end
            if (i_in_valid && i_in_ready) awaited.push_back(apply_command(i_in_data));
        end
        o_pending    <= awaited.size();
        o_fail_count <= fails;
    end

endmodule

FILE: sim/tuple_deque_remove_reverse_tb.sv
module tuple_deque_remove_reverse_tb;
    import tdrr_pkg::*;

    localparam logic [CMD_W-1:0]     CMD_SPARE    = 3'd7;
    localparam logic [WORD_BITS-1:0] WORD_MIN     = 32'h8000_0000;
    localparam logic [WORD_BITS-1:0] WORD_MAX     = 32'h7fff_ffff;
    localparam int                   RANDOM_ITEMS = 800;
    localparam int                   IDLE_LIMIT   = 2000;
    localparam int                   TAIL_CYCLES  = 40;
    localparam int                   POOL_SIZE    = 6;

    logic      clk       = 1'b0;
    logic      rst_n     = 1'b0;
    logic      in_valid  = 1'b0;
    logic      in_ready;
    t_in_item  in_data   = '0;
    logic      out_valid;
    logic      out_ready = 1'b0;
    t_out_item out_data;
    int        fail_count;
    int        pending;
    bit        steady    = 1'b0;
    int        hold_off  = 0;
    int        quiet     = 0;
    t_tuple    pool[POOL_SIZE];

    tuple_deque_remove_reverse dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_data  (out_data)
    );

    tdrr_result_monitor u_monitor (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_in_valid   (in_valid),
        .i_in_ready   (in_ready),
        .i_in_data    (in_data),
        .i_out_valid  (out_valid),
        .i_out_ready  (out_ready),
        .i_out_data   (out_data),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    always #4 clk = ~clk;

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (steady || r < 55) return 0;
        if (r < 88) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 40);
    endfunction

    function automatic logic [WORD_BITS-1:0] pick_word();
        case ($urandom_range(0, 7))
            0:       return WORD_MIN;
            1:       return WORD_MAX;
            2:       return '0;
            3:       return '1;
            default: return $urandom;
        endcase
    endfunction

    function automatic void refresh_pool();
        foreach (pool[i]) pool[i] = '{a: pick_word(), b: pick_word(), c: pick_word()};
    endfunction

    // phase 0 fills, 1 mixes, 2 drains
    function automatic logic [CMD_W-1:0] pick_cmd(input int phase);
        int r;
        int push_pct;
        int pop_pct;
        r        = $urandom_range(0, 99);
        push_pct = (phase == 0) ? 62 : (phase == 1) ? 38 : 18;
        pop_pct  = (phase == 0) ? 6 : (phase == 1) ? 14 : 32;
        if (r == 99) return CMD_SPARE;
        if (r < push_pct) return $urandom_range(0, 1) ? CMD_PUSH_FRONT : CMD_PUSH_BACK;
        r -= push_pct;
        if (r < pop_pct) return CMD_POP_FRONT;
        case (r % 4)
            0:       return CMD_REMOVE;
            1:       return CMD_REVERSE;
            2:       return CMD_SEARCH;
            default: return CMD_READ;
        endcase
    endfunction

    function automatic t_in_item make_item(input logic [CMD_W-1:0] cmd);
        t_in_item it;
        t_tuple   t;
        // mostly pool tuples so that search and remove hit
        if ($urandom_range(0, 3) != 0) t = pool[$urandom_range(0, POOL_SIZE - 1)];
        else t = '{a: $urandom, b: $urandom, c: $urandom};
        it.cmd      = cmd;
        it.word_a   = t.a;
        it.word_b   = t.b;
        it.word_c   = t.c;
        it.position = POS_W'($urandom_range(0, 15));
        return it;
    endfunction

    task automatic send_beat(input t_in_item it);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= it;
        do @(posedge clk); while (!in_ready);
    endtask

    task automatic send_cmd(input logic [CMD_W-1:0] cmd, input t_tuple t,
                            input logic [POS_W-1:0] pos);
        t_in_item it;
        it.cmd      = cmd;
        it.word_a   = t.a;
        it.word_b   = t.b;
        it.word_c   = t.c;
        it.position = pos;
        send_beat(it);
    endtask

    always @(posedge clk) begin
        if (!rst_n) begin
            out_ready <= 1'b0;
            hold_off  <= 0;
        end else if (steady) begin
            out_ready <= 1'b1;
            hold_off  <= 0;
        end else if (hold_off > 0) begin
            out_ready <= 1'b0;
            hold_off  <= hold_off - 1;
        end else begin
            out_ready <= 1'b1;
            if ($urandom_range(0, 2) == 0) hold_off <= pick_gap();
        end
    end

    // watchdog on cycles with no beat on either side
    always @(posedge clk) begin
        if ((in_valid && in_ready) || (out_valid && out_ready)) begin
            quiet <= 0;
        end else if (quiet >= IDLE_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
        end else begin
            quiet <= quiet + 1;
        end
    end

    initial begin
        t_tuple low_t;
        t_tuple high_t;
        t_tuple fill_t;
        low_t  = '{a: WORD_MIN, b: WORD_MAX, c: '0};
        high_t = '{a: WORD_MAX, b: WORD_MIN, c: '1};
        fill_t = '{a: WORD_MAX, b: WORD_MAX, c: WORD_MIN};
        refresh_pool();

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // empty store
        send_cmd(CMD_READ, low_t, '0);
        send_cmd(CMD_POP_FRONT, low_t, '0);
        send_cmd(CMD_REMOVE, low_t, '0);
        send_cmd(CMD_REVERSE, low_t, '0);
        send_cmd(CMD_SEARCH, low_t, '0);
        send_cmd(CMD_SPARE, high_t, '1);
        // small contents, duplicates, reverse, search hit and miss
        send_cmd(CMD_PUSH_BACK, low_t, '0);
        send_cmd(CMD_PUSH_FRONT, high_t, '0);
        send_cmd(CMD_PUSH_BACK, low_t, '0);
        send_cmd(CMD_READ, low_t, 4'd2);
        send_cmd(CMD_REVERSE, low_t, '0);
        send_cmd(CMD_READ, low_t, '0);
        send_cmd(CMD_SEARCH, high_t, '0);
        send_cmd(CMD_SEARCH, '{a: WORD_MAX, b: WORD_MIN, c: '0}, '0);
        send_cmd(CMD_REMOVE, low_t, '0);
        send_cmd(CMD_POP_FRONT, low_t, '0);
        // fill past full, read the last slot, then clear in one remove
        repeat (DEPTH + 1) send_cmd(CMD_PUSH_FRONT, fill_t, '0);
        send_cmd(CMD_READ, fill_t, 4'd15);
        send_cmd(CMD_REMOVE, fill_t, '0);
        send_cmd(CMD_READ, fill_t, '0);

        for (int k = 0; k < RANDOM_ITEMS; k++) begin
            if (k % 50 == 0) refresh_pool();
            steady <= ((k / 50) % 6 == 4);
            send_beat(make_item(pick_cmd((k / 60) % 3)));
        end
        in_valid <= 1'b0;
        steady   <= 1'b0;

        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);
        if (fail_count == 0 && pending == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule

FILE: tuple_deque_remove_reverse.f
hdl/tdrr_pkg.sv
hdl/tdrr_cell.sv
hdl/tuple_deque_remove_reverse.sv
sim/tdrr_result_monitor.sv
sim/tuple_deque_remove_reverse_tb.sv
